>>> rtl/core/fpd_pkg.sv
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants of the position frame decoder
// frame record, decoded result, configuration set, status and register codes
// ----------------------------------------------------------------------------
package fpd_pkg;

    // frame geometry
    localparam int MAX_FRAME_BYTES = 32;
    localparam int IDX_W           = $clog2(MAX_FRAME_BYTES);
    localparam int CAPTURE_BYTES   = 8;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_BIAS     = 3'd0,
        CFG_Y_BIAS     = 3'd1,
        CFG_AREA_MIN   = 3'd2,
        CFG_AREA_MAX   = 3'd3,
        CFG_ERR_LIMIT  = 3'd4
    } t_cfg_idx;

    // reported status codes
    typedef enum logic [3:0] {
        ST_GOOD      = 4'd0,
        ST_TILTED    = 4'd1,
        ST_CODE_COND = 4'd2,
        ST_NO_DIR    = 4'd3,
        ST_NO_COLOR  = 4'd4,
        ST_NO_POS    = 4'd5,
        ST_TIMEOUT   = 4'd6,
        ST_CHECKSUM  = 4'd7,
        ST_FATAL     = 4'd8
    } t_status;

    // sensor error codes (low 16 bits of the error field)
    localparam logic [15:0] CODE_TILTED    = 16'd1;
    localparam logic [15:0] CODE_COND      = 16'd2;
    localparam logic [15:0] CODE_NO_DIR    = 16'd5;
    localparam logic [15:0] CODE_NO_COLOR  = 16'd6;
    localparam logic [15:0] FATAL_CODE_MIN = 16'd1000;

    // position wrap constants
    localparam logic        [23:0] X_WRAP_THRESHOLD = 24'd100000;
    localparam logic signed [26:0] X_WRAP_SPAN      = 27'sd16777215;
    localparam logic        [14:0] Y_WRAP_THRESHOLD = 15'd1000;
    localparam logic signed [17:0] Y_WRAP_SPAN      = 18'sd16383;
    localparam logic signed [17:0] Y_SAT_MAX        = 18'sd32767;
    localparam logic signed [17:0] Y_SAT_MIN        = -18'sd32768;

    // header flag bits of byte 0
    localparam int FLAG_ERROR_BIT  = 0;
    localparam int FLAG_NO_POS_BIT = 1;

    // configuration reset values
    localparam logic signed [24:0] X_BIAS_RST    = 25'sd0;
    localparam logic signed [14:0] Y_BIAS_RST    = 15'sd0;
    localparam logic signed [25:0] AREA_MIN_RST  = -26'sd33554432;
    localparam logic signed [25:0] AREA_MAX_RST  = 26'sd33554431;
    localparam logic        [7:0]  ERR_LIMIT_RST = 8'd3;

    typedef struct packed {
        logic signed [24:0] x_bias;
        logic signed [14:0] y_bias;
        logic signed [25:0] area_min;
        logic signed [25:0] area_max;
        logic        [7:0]  err_limit;
    } t_cfg;

    // one finished frame as handed from front to back
    typedef struct packed {
        logic        failed;
        logic        sum_ok;
        logic [1:0]  flags;
        logic [23:0] raw_x;
        logic [14:0] raw_y;
    } t_frame_rec;

    // decoded frame ready for commit
    typedef struct packed {
        t_status            status;
        logic signed [25:0] x_val;
        logic signed [15:0] y_val;
    } t_dec;

endpackage

>>> rtl/core/fpd_front.sv
// ----------------------------------------------------------------------------
// fpd_front: frame byte intake
// running checksum, header capture and frame record assembly at the last byte
// ----------------------------------------------------------------------------
module fpd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_last_byte,
    input  logic                 i_comm_failed,
    output logic                 o_push,
    output fpd_pkg::t_frame_rec  o_rec
);

    logic [fpd_pkg::IDX_W-1:0] r_idx;
    logic [fpd_pkg::IDX_W-1:0] n_idx;
    logic [7:0]                r_xor;
    logic [7:0]                n_xor;
    logic [7:0]                r_cap [fpd_pkg::CAPTURE_BYTES];
    logic [7:0]                cap_now [fpd_pkg::CAPTURE_BYTES];
    logic                      idx_in_cap;
    logic                      idx_room;

    assign idx_in_cap = r_idx < fpd_pkg::IDX_W'(fpd_pkg::CAPTURE_BYTES);
    assign idx_room   = r_idx < fpd_pkg::IDX_W'(fpd_pkg::MAX_FRAME_BYTES - 1);

    // header bytes as seen with the current byte placed at its slot
    always_comb begin
        for (int k = 0; k < fpd_pkg::CAPTURE_BYTES; k++) begin
            cap_now[k] = (idx_in_cap && r_idx[2:0] == 3'(k)) ? i_rx_byte : r_cap[k];
        end
    end

    always_comb begin
        n_idx = r_idx;
        n_xor = r_xor;
        if (i_accept) begin
            if (i_last_byte) begin
                n_idx = '0;
                n_xor = '0;
            end else if (idx_room) begin
                n_idx = r_idx + 1'b1;
                n_xor = r_xor ^ i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_xor <= '0;
            for (int k = 0; k < fpd_pkg::CAPTURE_BYTES; k++) r_cap[k] <= '0;
        end else begin
            r_idx <= n_idx;
            r_xor <= n_xor;
            if (i_accept) begin
                if (i_last_byte) begin
                    for (int k = 0; k < fpd_pkg::CAPTURE_BYTES; k++) r_cap[k] <= '0;
                end else if (idx_room) begin
                    for (int k = 0; k < fpd_pkg::CAPTURE_BYTES; k++) r_cap[k] <= cap_now[k];
                end
            end
        end
    end

    assign o_push = i_accept && i_last_byte;

    always_comb begin
        o_rec.failed = i_comm_failed;
        o_rec.sum_ok = (i_rx_byte == r_xor);
        o_rec.flags  = cap_now[0][1:0];
        o_rec.raw_x  = 24'(cap_now[4]) | (24'(cap_now[3]) << 7) | (24'(cap_now[2]) << 14)
                     | (24'(cap_now[1][2:0]) << 21);
        o_rec.raw_y  = 15'(cap_now[7]) | (15'(cap_now[6]) << 7);
    end

endmodule

>>> rtl/core/fpd_queue.sv
// ----------------------------------------------------------------------------
// fpd_queue: frame record queue
// short fifo that decouples byte intake from frame decoding
// ----------------------------------------------------------------------------
module fpd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  fpd_pkg::t_frame_rec  i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output fpd_pkg::t_frame_rec  o_data
);

    localparam int PTR_W = (fpd_pkg::QUEUE_DEPTH > 1) ? $clog2(fpd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(fpd_pkg::QUEUE_DEPTH + 1);

    fpd_pkg::t_frame_rec r_mem [fpd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(fpd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = r_count == CNT_W'(fpd_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_next(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_next(r_rd_ptr);
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("frame queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("frame queue read while empty");

endmodule

>>> rtl/core/fpd_back.sv
// ----------------------------------------------------------------------------
// fpd_back: frame decode and commit
// classifies frames, decodes positions, runs the error filter, holds results
// ----------------------------------------------------------------------------
module fpd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpd_pkg::t_cfg        i_cfg,
    input  logic                 i_rec_valid,
    input  fpd_pkg::t_frame_rec  i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_frame_bad,
    output logic [3:0]           o_latched_status,
    output logic signed [25:0]   o_x_position,
    output logic signed [15:0]   o_y_position,
    output logic                 o_x_held
);

    // decode stage
    logic               r_dec_valid;
    fpd_pkg::t_dec      r_dec;
    fpd_pkg::t_dec      dec;
    fpd_pkg::t_status   cls;
    logic [15:0]        code;
    logic signed [26:0] x_sum;
    logic signed [17:0] y_sum;
    logic               out_ready;
    logic               commit;
    logic               load_dec;

    // commit stage
    logic               r_out_valid;
    logic               r_frame_bad;
    logic               r_x_held;
    logic signed [25:0] r_stored_x;
    logic signed [15:0] r_stored_y;
    logic [7:0]         r_bad_cnt;
    fpd_pkg::t_status   r_status;
    logic [7:0]         bad_inc;
    logic               in_area;

    assign out_ready = !r_out_valid || !i_stall;
    assign commit    = r_dec_valid && out_ready;
    assign load_dec  = !r_dec_valid || commit;
    assign o_pop     = i_rec_valid && load_dec;

    assign code = i_rec.raw_x[15:0];

    always_comb begin
        priority if (i_rec.failed)                        cls = fpd_pkg::ST_TIMEOUT;
        else if (!i_rec.sum_ok)                           cls = fpd_pkg::ST_CHECKSUM;
        else if (i_rec.flags[fpd_pkg::FLAG_ERROR_BIT]) begin
            priority if (code >= fpd_pkg::FATAL_CODE_MIN) cls = fpd_pkg::ST_FATAL;
            else if (code == fpd_pkg::CODE_TILTED)        cls = fpd_pkg::ST_TILTED;
            else if (code == fpd_pkg::CODE_COND)          cls = fpd_pkg::ST_CODE_COND;
            else if (code == fpd_pkg::CODE_NO_DIR)        cls = fpd_pkg::ST_NO_DIR;
            else if (code == fpd_pkg::CODE_NO_COLOR)      cls = fpd_pkg::ST_NO_COLOR;
            else                                          cls = fpd_pkg::ST_GOOD;
        end
        else if (i_rec.flags[fpd_pkg::FLAG_NO_POS_BIT])   cls = fpd_pkg::ST_NO_POS;
        else                                              cls = fpd_pkg::ST_GOOD;
    end

    // sign wrap and offset
    always_comb begin
        x_sum = $signed({3'b000, i_rec.raw_x})
              - ((i_rec.raw_x >= fpd_pkg::X_WRAP_THRESHOLD) ? fpd_pkg::X_WRAP_SPAN : 27'sd0)
              - $signed({{2{i_cfg.x_bias[24]}}, i_cfg.x_bias});
        y_sum = $signed({3'b000, i_rec.raw_y})
              - ((i_rec.raw_y >= fpd_pkg::Y_WRAP_THRESHOLD) ? fpd_pkg::Y_WRAP_SPAN : 18'sd0)
              - $signed({{3{i_cfg.y_bias[14]}}, i_cfg.y_bias});
        dec.status = cls;
        dec.x_val  = x_sum[25:0];
        if (y_sum > fpd_pkg::Y_SAT_MAX)      dec.y_val = fpd_pkg::Y_SAT_MAX[15:0];
        else if (y_sum < fpd_pkg::Y_SAT_MIN) dec.y_val = fpd_pkg::Y_SAT_MIN[15:0];
        else                                 dec.y_val = y_sum[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (load_dec) begin
            r_dec_valid <= i_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_dec <= dec;
    end

    assign bad_inc = r_bad_cnt + 1'b1;
    assign in_area = (r_dec.x_val >= i_cfg.area_min) && (r_dec.x_val <= i_cfg.area_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_frame_bad <= 1'b0;
            r_x_held    <= 1'b0;
            r_stored_x  <= '0;
            r_stored_y  <= '0;
            r_bad_cnt   <= '0;
            r_status    <= fpd_pkg::ST_GOOD;
        end else if (commit) begin
            r_out_valid <= 1'b1;
            if (r_dec.status != fpd_pkg::ST_GOOD) begin
                r_frame_bad <= 1'b1;
                r_x_held    <= 1'b0;
                if (bad_inc >= i_cfg.err_limit) begin
                    r_stored_x <= '0;
                    r_stored_y <= '0;
                    r_bad_cnt  <= '0;
                    r_status   <= r_dec.status;
                end else begin
                    r_bad_cnt  <= bad_inc;
                end
            end else begin
                r_frame_bad <= 1'b0;
                r_x_held    <= !in_area;
                if (in_area) r_stored_x <= r_dec.x_val;
                r_stored_y  <= r_dec.y_val;
                r_bad_cnt   <= '0;
                r_status    <= fpd_pkg::ST_GOOD;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_bad      = r_frame_bad;
    assign o_latched_status = r_status;
    assign o_x_position     = r_stored_x;
    assign o_y_position     = r_stored_y;
    assign o_x_held         = r_x_held;

    a_held_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_frame_bad) |-> !r_x_held) else $error("x held on a bad frame");

    a_good_clears_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_frame_bad) |-> (r_status == fpd_pkg::ST_GOOD))
        else $error("good frame left a latched status");

    a_latch_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != fpd_pkg::ST_GOOD) |-> (r_stored_x == '0 && r_stored_y == '0))
        else $error("positions not cleared while status latched");

endmodule

>>> rtl/core/position_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// position_frame_decoder_core: optical position sensor frame decoder
// checks, classifies and decodes sensor response frames into positions
// ----------------------------------------------------------------------------
// usage
//  - input channel (i_valid / o_stall): one frame byte per request; i_last_byte
//    marks the checksum byte, i_comm_failed is sampled with it
//  - output channel (o_valid / i_stall): one result request per frame, none for
//    other bytes; positions and status are the stored values after the frame
//  - config port: i_cfg_we writes i_cfg_data into register i_cfg_index
//    (0 x offset, 1 y offset, 2 area min, 3 area max, 4 error limit); other
//    indexes are ignored; user must write only while no frame is in flight
//  - throughput: one byte per cycle while o_stall is low
//  - the edge that takes the checksum byte writes the frame record into the
//    queue; it then passes the decode stage and the commit register to o_valid
//  - a two-entry frame queue sits between byte intake and decode; o_stall
//    rises only while it is full, i.e. when the receiver stalls long enough
//    for three more finished frames to pile up behind the held result
//    (one in the decode stage, two in the queue)
//  - a stalled result holds its value; reset clears the byte counter,
//    checksum, header capture, stored positions and error filter, and puts
//    the config registers back to their reset values
// ----------------------------------------------------------------------------
module position_frame_decoder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_last_byte,
    input  logic                 i_comm_failed,
    // result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_frame_bad,
    output logic [3:0]           o_latched_status,
    output logic signed [25:0]   o_x_position,
    output logic signed [15:0]   o_y_position,
    output logic                 o_x_held,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    fpd_pkg::t_cfg        r_cfg;
    fpd_pkg::t_frame_rec  front_rec;
    fpd_pkg::t_frame_rec  queue_rec;
    logic                 in_accept;
    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 queue_valid;

    // configuration registers, each truncated to its own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_bias    <= fpd_pkg::X_BIAS_RST;
            r_cfg.y_bias    <= fpd_pkg::Y_BIAS_RST;
            r_cfg.area_min  <= fpd_pkg::AREA_MIN_RST;
            r_cfg.area_max  <= fpd_pkg::AREA_MAX_RST;
            r_cfg.err_limit <= fpd_pkg::ERR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (fpd_pkg::t_cfg_idx'(i_cfg_index))
                fpd_pkg::CFG_X_BIAS:    r_cfg.x_bias    <= i_cfg_data[24:0];
                fpd_pkg::CFG_Y_BIAS:    r_cfg.y_bias    <= i_cfg_data[14:0];
                fpd_pkg::CFG_AREA_MIN:  r_cfg.area_min  <= i_cfg_data[25:0];
                fpd_pkg::CFG_AREA_MAX:  r_cfg.area_max  <= i_cfg_data[25:0];
                fpd_pkg::CFG_ERR_LIMIT: r_cfg.err_limit <= i_cfg_data[7:0];
                default:                r_cfg           <= r_cfg;
            endcase
        end
    end

    // byte request taken whenever the frame queue has room
    assign o_stall   = queue_full;
    assign in_accept = i_valid && !queue_full;

    fpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_rx_byte     (i_rx_byte),
        .i_last_byte   (i_last_byte),
        .i_comm_failed (i_comm_failed),
        .o_push        (push),
        .o_rec         (front_rec)
    );

    fpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_rec),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_data  (queue_rec)
    );

    fpd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_rec_valid      (queue_valid),
        .i_rec            (queue_rec),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_bad      (o_frame_bad),
        .o_latched_status (o_latched_status),
        .o_x_position     (o_x_position),
        .o_y_position     (o_y_position),
        .o_x_held         (o_x_held)
    );

endmodule

>>> dv/position_frame_decoder_core_test.sv
// ----------------------------------------------------------------------------
// position_frame_decoder_core_test: self-checking bench of the frame decoder
// drives sensor response frames byte by byte under random idle and stall,
// predicts status and positions for every frame end and compares each result
// ----------------------------------------------------------------------------
module position_frame_decoder_core_test;

    // run length and timing
    localparam int          PHASES        = 8;
    localparam int          PHASE_BYTES   = 185;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // wrap and saturation constants of the position decode, in counts
    localparam longint X_WRAP_AT = 100000;
    localparam longint X_SPAN    = 16777215;
    localparam longint Y_WRAP_AT = 1000;
    localparam longint Y_SPAN    = 16383;
    localparam longint Y_TOP     = 32767;
    localparam longint Y_BOTTOM  = -32768;

    typedef logic [7:0] t_frame_bytes[$];

    // one result request as seen on the output channel
    typedef struct packed {
        logic               bad;
        fpd_pkg::t_status   status;
        logic signed [25:0] x_pos;
        logic signed [15:0] y_pos;
        logic               held;
    } t_frame_result;

    // ------------------------------------------------------------------------
    // scoreboard: tracks the frame under intake and the position store,
    // queues the expected result of every frame end and checks the outputs
    // ------------------------------------------------------------------------
    class frame_result_scoreboard;
        // configuration copy
        longint      x_bias;
        longint      y_bias;
        longint      area_min;
        longint      area_max;
        int unsigned err_limit;
        // frame intake and position store
        int unsigned byte_count;
        logic [7:0]  check_xor;
        logic [7:0]  header[fpd_pkg::CAPTURE_BYTES];
        longint      pos_x;
        longint      pos_y;
        int unsigned bad_run;
        fpd_pkg::t_status latch;
        t_frame_result pending_results[$];
        int unsigned mismatches;

        function new();
            x_bias     = 0;
            y_bias     = 0;
            area_min   = -33554432;
            area_max   = 33554431;
            err_limit  = 3;
            pos_x      = 0;
            pos_y      = 0;
            bad_run    = 0;
            latch      = fpd_pkg::ST_GOOD;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count = 0;
            check_xor  = 8'h00;
            foreach (header[k]) header[k] = 8'h00;
        endfunction

        function void write_reg(fpd_pkg::t_cfg_idx idx, logic [fpd_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                fpd_pkg::CFG_X_BIAS:    x_bias    = longint'($signed(val[24:0]));
                fpd_pkg::CFG_Y_BIAS:    y_bias    = longint'($signed(val[14:0]));
                fpd_pkg::CFG_AREA_MIN:  area_min  = longint'($signed(val[25:0]));
                fpd_pkg::CFG_AREA_MAX:  area_max  = longint'($signed(val[25:0]));
                fpd_pkg::CFG_ERR_LIMIT: err_limit = val[7:0];
                default: ;
            endcase
        endfunction

        // 24-bit error / X field, the byte pieces are ORed, not added
        function logic [23:0] error_field();
            logic [23:0] v;
            v = 24'(header[4]);
            v |= 24'(header[3]) << 7;
            v |= 24'(header[2]) << 14;
            v |= 24'(header[1][2:0]) << 21;
            return v;
        endfunction

        function fpd_pkg::t_status classify_frame(bit failed, logic [7:0] sum_byte);
            logic [23:0] field;
            logic [15:0] code;
            field = error_field();
            code  = field[15:0];
            if (failed) return fpd_pkg::ST_TIMEOUT;
            if (sum_byte != check_xor) return fpd_pkg::ST_CHECKSUM;
            if (header[0][fpd_pkg::FLAG_ERROR_BIT]) begin
                if (code >= fpd_pkg::FATAL_CODE_MIN) return fpd_pkg::ST_FATAL;
                if (code == fpd_pkg::CODE_TILTED) return fpd_pkg::ST_TILTED;
                if (code == fpd_pkg::CODE_COND) return fpd_pkg::ST_CODE_COND;
                if (code == fpd_pkg::CODE_NO_DIR) return fpd_pkg::ST_NO_DIR;
                if (code == fpd_pkg::CODE_NO_COLOR) return fpd_pkg::ST_NO_COLOR;
                return fpd_pkg::ST_GOOD;
            end
            if (header[0][fpd_pkg::FLAG_NO_POS_BIT]) return fpd_pkg::ST_NO_POS;
            return fpd_pkg::ST_GOOD;
        endfunction

        // frame end: classify, decode, run the error filter, queue the result
        function void predict_frame_end(logic [7:0] sum_byte, bit failed);
            fpd_pkg::t_status st;
            t_frame_result    res;
            longint           raw_x;
            longint           raw_y;
            longint           nx;
            longint           ny;
            if (byte_count < fpd_pkg::CAPTURE_BYTES) header[byte_count] = sum_byte;
            st       = classify_frame(failed, sum_byte);
            res.held = 1'b0;
            if (st != fpd_pkg::ST_GOOD) begin
                res.bad = 1'b1;
                bad_run = (bad_run + 1) & 8'hFF;
                if (bad_run >= err_limit) begin
                    pos_x   = 0;
                    pos_y   = 0;
                    bad_run = 0;
                    latch   = st;
                end
            end else begin
                res.bad = 1'b0;
                raw_x   = longint'(error_field());
                raw_y   = longint'(header[7]) | (longint'(header[6]) << 7);
                nx = (raw_x >= X_WRAP_AT) ? raw_x - X_SPAN - x_bias : raw_x - x_bias;
                ny = (raw_y >= Y_WRAP_AT) ? raw_y - Y_SPAN - y_bias : raw_y - y_bias;
                if (ny > Y_TOP) ny = Y_TOP;
                if (ny < Y_BOTTOM) ny = Y_BOTTOM;
                if (nx >= area_min && nx <= area_max) pos_x = nx;
                else res.held = 1'b1;
                pos_y   = ny;
                bad_run = 0;
                latch   = fpd_pkg::ST_GOOD;
            end
            res.status = latch;
            res.x_pos  = pos_x[25:0];
            res.y_pos  = pos_y[15:0];
            pending_results.push_back(res);
            clear_frame();
        endfunction

        function void note_byte(logic [7:0] b, bit last, bit failed);
            if (last) begin
                predict_frame_end(b, failed);
            end else if (byte_count < fpd_pkg::MAX_FRAME_BYTES - 1) begin
                // bytes past the frame size are dropped until the checksum
                if (byte_count < fpd_pkg::CAPTURE_BYTES) header[byte_count] = b;
                check_xor ^= b;
                byte_count++;
            end
        endfunction

        task report(string what, longint got, longint want);
            mismatches++;
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        endtask

        task check_result(t_frame_result got);
            t_frame_result want;
            if (pending_results.size() == 0) begin
                report("result with no frame pending", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.bad != want.bad) report("frame_bad", got.bad, want.bad);
                if (got.status != want.status)
                    report("latched_status", got.status, want.status);
                if (got.x_pos != want.x_pos)
                    report("x_position", longint'(got.x_pos), longint'(want.x_pos));
                if (got.y_pos != want.y_pos)
                    report("y_position", longint'(got.y_pos), longint'(want.y_pos));
                if (got.held != want.held) report("x_held", got.held, want.held);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // block ports, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_valid       = 1'b0;
    logic                           o_stall;
    logic [7:0]                     i_rx_byte     = 8'h00;
    logic                           i_last_byte   = 1'b0;
    logic                           i_comm_failed = 1'b0;
    logic                           o_valid;
    logic                           i_stall       = 1'b0;
    logic                           o_frame_bad;
    logic [3:0]                     o_latched_status;
    logic signed [25:0]             o_x_position;
    logic signed [15:0]             o_y_position;
    logic                           o_x_held;
    logic                           i_cfg_we      = 1'b0;
    logic [fpd_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [fpd_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    // idling in percent of cycles, changed per phase
    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;

    frame_result_scoreboard sb = new();

    position_frame_decoder_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_last_byte      (i_last_byte),
        .i_comm_failed    (i_comm_failed),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_bad      (o_frame_bad),
        .o_latched_status (o_latched_status),
        .o_x_position     (o_x_position),
        .o_y_position     (o_y_position),
        .o_x_held         (o_x_held),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("position_frame_decoder_core test failed");
            $finish;
        end
    end

    // result side: outputs sampled at the edge, stall redrawn every cycle
    always @(posedge i_clk) begin : result_sink
        t_frame_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.bad    = o_frame_bad;
            got.status = fpd_pkg::t_status'(o_latched_status);
            got.x_pos  = o_x_position;
            got.y_pos  = o_y_position;
            got.held   = o_x_held;
            sb.check_result(got);
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [7:0] xor_bytes(t_frame_bytes data, int n);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < n && k < data.size(); k++) acc ^= data[k];
        return acc;
    endfunction

    // one byte request; random idle cycles ahead of it, then hold until taken
    task automatic send_byte(logic [7:0] b, bit last, bit failed);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_last_byte   <= last;
        i_comm_failed <= failed;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b, last, failed);
        bytes_sent++;
    endtask

    // body bytes carry a random timeout flag, it only counts on the checksum
    task automatic send_frame(t_frame_bytes data, logic [7:0] sum_byte, bit failed);
        foreach (data[k]) send_byte(data[k], 1'b0, $urandom_range(1));
        send_byte(sum_byte, 1'b1, failed);
    endtask

    // hold the sender until every pending result is out and the pipe is empty
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(fpd_pkg::t_cfg_idx idx, logic [fpd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // per-phase register set: extremes first, random windows afterwards
    task automatic apply_setting(int ph);
        longint x_off;
        longint y_off;
        longint lo;
        longint hi;
        longint mid;
        longint span;
        logic [7:0] limit;
        case (ph)
            0: begin
                x_off = 0; y_off = 0; lo = -33554432; hi = 33554431; limit = 8'd1;
            end
            1: begin
                x_off = -16777216; y_off = 16383; lo = -1000; hi = 50000; limit = 8'd255;
            end
            2: begin
                // zero limit: every bad frame latches at once
                x_off = 16777215; y_off = -16384; lo = -33554432; hi = 33554431;
                limit = 8'd0;
            end
            3: begin
                // area pinned at the top: nearly every X is held
                x_off = 0; y_off = -16384; lo = 33554431; hi = 33554431; limit = 8'd2;
            end
            default: begin
                x_off = longint'($urandom);
                y_off = longint'($urandom);
                mid   = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
                span  = longint'($urandom_range(0, 1 << 24));
                lo    = mid - span;
                hi    = mid + span;
                case ($urandom_range(3))
                    0: limit = 8'd1;
                    1: limit = 8'd2;
                    2: limit = 8'd3;
                    default: limit = 8'($urandom_range(1, 255));
                endcase
            end
        endcase
        write_reg(fpd_pkg::CFG_X_BIAS, x_off[fpd_pkg::CFG_DATA_W-1:0]);
        write_reg(fpd_pkg::CFG_Y_BIAS, y_off[fpd_pkg::CFG_DATA_W-1:0]);
        write_reg(fpd_pkg::CFG_AREA_MIN, lo[fpd_pkg::CFG_DATA_W-1:0]);
        write_reg(fpd_pkg::CFG_AREA_MAX, hi[fpd_pkg::CFG_DATA_W-1:0]);
        write_reg(fpd_pkg::CFG_ERR_LIMIT, fpd_pkg::CFG_DATA_W'(limit));
    endtask

    // mostly well-formed eight-byte frames with random content,
    // the rest short, long, broken or plain noise
    task automatic send_random_frame();
        t_frame_bytes data;
        logic [23:0]  field;
        logic [14:0]  y_raw;
        logic [7:0]   head;
        logic [7:0]   sum_byte;
        int unsigned  kind;
        int unsigned  len;
        bit           failed;
        kind   = $urandom_range(99);
        failed = 1'b0;
        if (kind < 80) begin
            case ($urandom_range(4))
                0: field = 24'd0;
                1: field = 24'd99999;
                2: field = 24'd100000;
                3: field = 24'hFFFFFF;
                default: field = 24'($urandom);
            endcase
            case ($urandom_range(4))
                0: y_raw = 15'd0;
                1: y_raw = 15'd999;
                2: y_raw = 15'd1000;
                3: y_raw = 15'h7FFF;
                default: y_raw = 15'($urandom);
            endcase
            head = 8'($urandom);
            if (kind < 45) begin
                head[fpd_pkg::FLAG_ERROR_BIT]  = 1'b0;
                head[fpd_pkg::FLAG_NO_POS_BIT] = 1'b0;
            end else if (kind < 62) begin
                // sensor error codes, listed and unlisted ones
                head[fpd_pkg::FLAG_ERROR_BIT] = 1'b1;
                case ($urandom_range(10))
                    0: field[15:0] = fpd_pkg::CODE_TILTED;
                    1: field[15:0] = fpd_pkg::CODE_COND;
                    2: field[15:0] = fpd_pkg::CODE_NO_DIR;
                    3: field[15:0] = fpd_pkg::CODE_NO_COLOR;
                    4: field[15:0] = fpd_pkg::FATAL_CODE_MIN;
                    5: field[15:0] = fpd_pkg::FATAL_CODE_MIN - 16'd1;
                    6: field[15:0] = 16'hFFFF;
                    7: field[15:0] = 16'd0;
                    8: field[15:0] = 16'd3;
                    9: field[15:0] = 16'd4;
                    default: field[15:0] = 16'($urandom);
                endcase
            end else if (kind < 70) begin
                head[fpd_pkg::FLAG_ERROR_BIT]  = 1'b0;
                head[fpd_pkg::FLAG_NO_POS_BIT] = 1'b1;
            end
            data = {head, {5'($urandom), field[23:21]}, {1'b0, field[20:14]},
                    {1'b0, field[13:7]}, {1'b0, field[6:0]}, 8'($urandom),
                    y_raw[14:7], {1'b0, y_raw[6:0]}};
            // stray top bits overlap the next piece of the ORed fields
            if ($urandom_range(3) == 0) begin
                data[2][7] = $urandom_range(1);
                data[3][7] = $urandom_range(1);
                data[4][7] = $urandom_range(1);
                data[7][7] = $urandom_range(1);
            end
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3)) data.push_back(8'($urandom));
            sum_byte = xor_bytes(data, data.size());
            if (kind >= 70 && kind < 75) sum_byte ^= 8'($urandom_range(1, 255));
            failed = (kind >= 75);
        end else if (kind < 88) begin
            // short frame: missing header bytes read as zero
            len = $urandom_range(0, 7);
            repeat (len) data.push_back(8'($urandom));
            sum_byte = xor_bytes(data, len);
            if ($urandom_range(3) == 0) sum_byte = 8'($urandom);
        end else if (kind < 93) begin
            // long frame: bytes past the frame size are neither summed nor kept
            len = $urandom_range(fpd_pkg::MAX_FRAME_BYTES - 2, fpd_pkg::MAX_FRAME_BYTES + 8);
            repeat (len) data.push_back(8'($urandom));
            if ($urandom_range(1)) sum_byte = xor_bytes(data, fpd_pkg::MAX_FRAME_BYTES - 1);
            else sum_byte = xor_bytes(data, len);
        end else begin
            len = $urandom_range(0, 12);
            repeat (len) data.push_back(8'($urandom));
            sum_byte = 8'($urandom);
            failed   = ($urandom_range(7) == 0);
        end
        send_frame(data, sum_byte, failed);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned  start;
        t_frame_bytes no_bytes;
        t_frame_bytes body;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at reset settings, limit 3
        // checksum alone at index 0: good frame, everything reads as zero
        send_frame(no_bytes, 8'h00, 1'b0);
        // timeout, then checksum error, then fatal code: third bad frame latches
        send_frame(no_bytes, 8'hFF, 1'b1);
        body = {8'h01};
        send_frame(body, 8'h00, 1'b0);
        body = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(body, 8'h00, 1'b0);
        // good frame: largest X field wraps to zero, largest Y field
        body = {8'h00, 8'h07, 8'h7F, 8'h7F, 8'h7F, 8'hA5, 8'hFF, 8'hFF};
        send_frame(body, xor_bytes(body, 8), 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            apply_setting(ph);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) send_random_frame();
        end

        wait_idle();
        if (sb.mismatches == 0) begin
            $display("position_frame_decoder_core test passed");
        end else begin
            $display("position_frame_decoder_core test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/fpd_pkg.sv
rtl/core/fpd_front.sv
rtl/core/fpd_queue.sv
rtl/core/fpd_back.sv
rtl/core/position_frame_decoder_core.sv
dv/position_frame_decoder_core_test.sv
